// ===== hw/rtl/bps_pkg.sv =====
package bps_pkg;

    typedef enum logic [2:0] {
        REG_LIGHT_DIR     = 3'd0,
        REG_LIGHT_COLOR   = 3'd1,
        REG_AMBIENT_COLOR = 3'd2,
        REG_EYE_X         = 3'd3,
        REG_EYE_Y         = 3'd4,
        REG_EYE_Z         = 3'd5,
        REG_SHININESS     = 3'd6
    } cfg_reg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int COL_W      = 16;
    localparam int DIR_W      = 16;
    localparam int POS_W      = 24;
    localparam int VEC_W      = 25;
    localparam int UNIT_W     = 15;
    localparam int NORM_PAD   = 6;
    localparam int QUOT_W     = 14;
    localparam int DOT_SUM_W  = 29;
    localparam int DOT_W      = 17;
    localparam int SUM_W      = 18;
    localparam int POW_STEPS  = 8;

    localparam logic [UNIT_W-1:0] UNIT_Q13 = 15'd8192;
    localparam logic [DOT_W-1:0]  ONE_Q16  = 17'd65536;

    localparam logic [CFG_DATA_W-1:0] LIGHT_DIR_RST   = 48'd8192;
    localparam logic [CFG_DATA_W-1:0] LIGHT_COLOR_RST = 48'hFFFF_FFFF_FFFF;
    localparam logic [7:0]            SHININESS_RST   = 8'd10;

    // register stages through one normalize unit for a component width w
    function automatic int nrm_latency(input int w);
        return w + NORM_PAD + QUOT_W + 2;
    endfunction

    // clamp a Q2.26 dot product to [0, 1.0] and return it as Q16
    function automatic logic [DOT_W-1:0] clamp_dot(input logic signed [DOT_SUM_W-1:0] d);
        logic [DOT_W-1:0] r;
        if (d < 0)
        begin
            r = '0;
        end
        else if (d > 29'sd67108864)
        begin
            r = ONE_Q16;
        end
        else
        begin
            r = d[26:10];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bps_normalize.sv =====
module bps_normalize
    import bps_pkg::*;
#(
    parameter int W = 25
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [2:0][W-1:0]       vec,
    output logic [2:0][UNIT_W-1:0]  dir_out
);

    localparam int SW   = 2 * W;
    localparam int RW   = W + NORM_PAD;
    localparam int NW   = 2 * RW;
    localparam int NDIV = QUOT_W;

    typedef struct packed {
        logic [2:0][W-1:0] mag;
        logic [2:0]        sgn;
        logic              zero;
    } side_t;

    side_t side_reg [0:RW+NDIV];

    // square and sum stage
    logic [2:0][W-1:0] mag_c;
    logic [2:0]        sgn_c;
    logic [SW-1:0]     sq_c [3];
    logic [SW-1:0]     sum_c;
    logic [SW-1:0]     s_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sgn_c[i] = vec[i][W-1];
            mag_c[i] = sgn_c[i] ? W'(-vec[i]) : vec[i];
            sq_c[i]  = SW'(mag_c[i]) * SW'(mag_c[i]);
        end
        sum_c = sq_c[0] + sq_c[1] + sq_c[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg            <= sum_c;
            side_reg[0].mag  <= mag_c;
            side_reg[0].sgn  <= sgn_c;
            side_reg[0].zero <= (sum_c == '0);
        end
    end

    // square root, one result bit per stage
    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [NW-1:0] nsh_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [NW-1:0] n_in;
        logic [RW+1:0] r2;
        logic [RW+1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = {s_reg, {(2*NORM_PAD){1'b0}}};
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign n_in    = nsh_reg[k-1];
        end

        assign r2    = {rem_in[RW-1:0], n_in[NW-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = (r2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]    <= ge ? (r2 - trial) : r2;
                root_reg[k]   <= {root_in[RW-2:0], ge};
                nsh_reg[k]    <= n_in << 2;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // restoring divide of |c| * 2^19 by the root, one quotient bit per stage
    logic [2:0][RW-1:0]     r_reg   [NDIV];
    logic [2:0][QUOT_W-1:0] q_reg   [NDIV];
    logic [2:0]             ovf_reg [NDIV];
    logic [RW-1:0]          dr_reg  [NDIV];

    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        logic [2:0][RW-1:0]     r_in;
        logic [2:0][QUOT_W-1:0] q_in;
        logic [2:0]             ovf_in;
        logic [RW-1:0]          root_in;
        logic [2:0][RW-1:0]     r_nx;
        logic [2:0][QUOT_W-1:0] q_nx;

        if (j == 0)
        begin : g_first
            assign root_in = root_reg[RW-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign r_in[i]   = RW'({side_reg[RW].mag[i], 5'b0});
                assign ovf_in[i] = (RW'({side_reg[RW].mag[i], 5'b0}) >= root_in);
                assign q_in[i]   = '0;
            end
        end
        else
        begin : g_next
            assign root_in = dr_reg[j-1];
            assign r_in    = r_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign ovf_in  = ovf_reg[j-1];
        end

        always_comb
        begin
            logic [RW:0] r2;
            logic        ge;
            for (int i = 0; i < 3; i++)
            begin
                r2      = {r_in[i], 1'b0};
                ge      = (r2 >= {1'b0, root_in});
                r_nx[i] = ge ? RW'(r2 - {1'b0, root_in}) : r2[RW-1:0];
                q_nx[i] = {q_in[i][QUOT_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]           <= r_nx;
                q_reg[j]           <= q_nx;
                ovf_reg[j]         <= ovf_in;
                dr_reg[j]          <= root_in;
                side_reg[RW+1+j]   <= side_reg[RW+j];
            end
        end
    end

    // clamp to one, restore sign, zero length gives zero
    logic [2:0][UNIT_W-1:0] unit_c;
    logic [2:0][UNIT_W-1:0] unit_reg;

    always_comb
    begin
        logic [UNIT_W-1:0] m;
        for (int i = 0; i < 3; i++)
        begin
            if (ovf_reg[NDIV-1][i] || (UNIT_W'(q_reg[NDIV-1][i]) > UNIT_Q13))
            begin
                m = UNIT_Q13;
            end
            else
            begin
                m = UNIT_W'(q_reg[NDIV-1][i]);
            end
            if (side_reg[RW+NDIV].zero)
            begin
                unit_c[i] = '0;
            end
            else
            begin
                unit_c[i] = side_reg[RW+NDIV].sgn[i] ? -m : m;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_c;
        end
    end

    assign dir_out = unit_reg;

endmodule

// ===== hw/rtl/blinn_phong_pixel_shader_unit.sv =====
// Blinn-Phong fragment shader, one fragment per clock unless stalled.
// Input channel (in_valid/in_ready): albedo r,g,b (Q0.16), unnormalized
// normal x,y,z (Q2.13) and world position x,y,z (Q12.12). Output channel
// (out_valid/out_ready): shaded color r,g,b (Q0.16), saturated.
// Light direction, light and ambient color, eye position and shininess sit
// in registers written through cfg_we/cfg_index/cfg_data; write them only
// while no transaction is in flight.
// The pipeline depth from input transaction to out_valid is set
// by two chained normalize units (bit-serial square root followed by a
// 14-bit restoring divide, one bit per stage), an 8-stage power unit and
// two color stages. Throughput: one transaction per clock unless stalled.
// A two-entry output buffer (output register plus skid entry) sits at the
// end. When the receiver stalls, the pipeline keeps moving until the skid
// entry fills; in_ready then drops and the whole pipeline holds until the
// receiver takes a transaction. in_ready is a register output.
// Reset clears all valid bits and loads the register defaults: light along
// +x, white light, black ambient, eye at origin, shininess 10.
module blinn_phong_pixel_shader_unit
    import bps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COL_W-1:0]      albedo_r,
    input  logic [COL_W-1:0]      albedo_g,
    input  logic [COL_W-1:0]      albedo_b,
    input  logic [DIR_W-1:0]      normal_x,
    input  logic [DIR_W-1:0]      normal_y,
    input  logic [DIR_W-1:0]      normal_z,
    input  logic [POS_W-1:0]      world_x,
    input  logic [POS_W-1:0]      world_y,
    input  logic [POS_W-1:0]      world_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COL_W-1:0]      color_r,
    output logic [COL_W-1:0]      color_g,
    output logic [COL_W-1:0]      color_b
);

    localparam int L1  = nrm_latency(VEC_W);
    localparam int L2  = nrm_latency(DIR_W);
    localparam int IH  = L1 + 1;
    localparam int ID  = IH + L2 + 1;
    localparam int IC1 = ID + POW_STEPS + 1;
    localparam int IC2 = IC1 + 1;
    localparam int DIFF_LAST = IC1 - 1 - IH;

    // configuration registers
    logic [CFG_DATA_W-1:0] light_dir_reg;
    logic [CFG_DATA_W-1:0] light_color_reg;
    logic [CFG_DATA_W-1:0] ambient_color_reg;
    logic [POS_W-1:0]      eye_x_reg;
    logic [POS_W-1:0]      eye_y_reg;
    logic [POS_W-1:0]      eye_z_reg;
    logic [7:0]            shininess_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_dir_reg     <= LIGHT_DIR_RST;
            light_color_reg   <= LIGHT_COLOR_RST;
            ambient_color_reg <= '0;
            eye_x_reg         <= '0;
            eye_y_reg         <= '0;
            eye_z_reg         <= '0;
            shininess_reg     <= SHININESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LIGHT_DIR:     light_dir_reg     <= cfg_data;
                REG_LIGHT_COLOR:   light_color_reg   <= cfg_data;
                REG_AMBIENT_COLOR: ambient_color_reg <= cfg_data;
                REG_EYE_X:         eye_x_reg         <= cfg_data[POS_W-1:0];
                REG_EYE_Y:         eye_y_reg         <= cfg_data[POS_W-1:0];
                REG_EYE_Z:         eye_z_reg         <= cfg_data[POS_W-1:0];
                REG_SHININESS:     shininess_reg     <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // pipeline enable: hold everything while the skid entry is occupied
    logic skid_full_reg;
    logic en;
    assign en       = !skid_full_reg;
    assign in_ready = en;

    logic vld_reg [0:IC2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= IC2; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= IC2; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // input stage: form the view vector, widen the normal and light
    logic [2:0][VEC_W-1:0]  n_reg;
    logic [2:0][VEC_W-1:0]  l_reg;
    logic [2:0][VEC_W-1:0]  v_reg;
    logic [2:0][COL_W-1:0]  alb_pipe [0:IC1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= VEC_W'($signed(normal_x));
            n_reg[1] <= VEC_W'($signed(normal_y));
            n_reg[2] <= VEC_W'($signed(normal_z));
            for (int i = 0; i < 3; i++)
            begin
                l_reg[i] <= VEC_W'($signed(light_dir_reg[16*i +: DIR_W]));
            end
            v_reg[0] <= VEC_W'($signed(eye_x_reg)) - VEC_W'($signed(world_x));
            v_reg[1] <= VEC_W'($signed(eye_y_reg)) - VEC_W'($signed(world_y));
            v_reg[2] <= VEC_W'($signed(eye_z_reg)) - VEC_W'($signed(world_z));
            alb_pipe[0] <= {albedo_b, albedo_g, albedo_r};
            for (int k = 1; k <= IC1; k++)
            begin
                alb_pipe[k] <= alb_pipe[k-1];
            end
        end
    end

    logic [2:0][UNIT_W-1:0] nu;
    logic [2:0][UNIT_W-1:0] lu;
    logic [2:0][UNIT_W-1:0] vu;
    logic [2:0][UNIT_W-1:0] hu;

    bps_normalize #(.W(VEC_W)) u_nrm_n (.clk(clk), .en(en), .vec(n_reg), .dir_out(nu));
    bps_normalize #(.W(VEC_W)) u_nrm_l (.clk(clk), .en(en), .vec(l_reg), .dir_out(lu));
    bps_normalize #(.W(VEC_W)) u_nrm_v (.clk(clk), .en(en), .vec(v_reg), .dir_out(vu));

    // half vector and diffuse term
    logic [2:0][DIR_W-1:0]   h_reg;
    logic [2:0][UNIT_W-1:0]  nu_pipe   [0:L2];
    logic [DOT_W-1:0]        diff_pipe [0:DIFF_LAST];
    logic signed [DOT_SUM_W-1:0] dl_c;
    logic signed [DOT_SUM_W-1:0] dh_c;

    always_comb
    begin
        dl_c = '0;
        dh_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            dl_c = dl_c + DOT_SUM_W'($signed(nu[i]) * $signed(lu[i]));
            dh_c = dh_c + DOT_SUM_W'($signed(nu_pipe[L2][i]) * $signed(hu[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                h_reg[i] <= DIR_W'($signed(lu[i])) + DIR_W'($signed(vu[i]));
            end
            nu_pipe[0]   <= nu;
            diff_pipe[0] <= clamp_dot(dl_c);
            for (int k = 1; k <= L2; k++)
            begin
                nu_pipe[k] <= nu_pipe[k-1];
            end
            for (int k = 1; k <= DIFF_LAST; k++)
            begin
                diff_pipe[k] <= diff_pipe[k-1];
            end
        end
    end

    bps_normalize #(.W(DIR_W)) u_nrm_h (.clk(clk), .en(en), .vec(h_reg), .dir_out(hu));

    // specular base, then square-and-multiply over the shininess bits
    logic [DOT_W-1:0] spec_base_reg;
    logic [DOT_W-1:0] pw_acc_reg  [POW_STEPS];
    logic [DOT_W-1:0] pw_base_reg [POW_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec_base_reg <= clamp_dot(dh_c);
        end
    end

    for (genvar k = 0; k < POW_STEPS; k++)
    begin : g_pow
        logic [DOT_W-1:0] acc_in;
        logic [DOT_W-1:0] base_in;
        logic [2*DOT_W-1:0] p_acc;
        logic [2*DOT_W-1:0] p_base;

        if (k == 0)
        begin : g_first
            assign acc_in  = ONE_Q16;
            assign base_in = spec_base_reg;
        end
        else
        begin : g_next
            assign acc_in  = pw_acc_reg[k-1];
            assign base_in = pw_base_reg[k-1];
        end

        assign p_acc  = (2*DOT_W)'(acc_in) * (2*DOT_W)'(base_in);
        assign p_base = (2*DOT_W)'(base_in) * (2*DOT_W)'(base_in);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pw_acc_reg[k]  <= shininess_reg[k] ? p_acc[16 +: DOT_W] : acc_in;
                pw_base_reg[k] <= p_base[16 +: DOT_W];
            end
        end
    end

    // color: ambient + light * (diffuse + specular), then times albedo
    logic [SUM_W-1:0]          sum_c;
    logic [2:0][SUM_W-1:0]     total_reg;
    logic [2:0][COL_W-1:0]     col_reg;

    assign sum_c = SUM_W'(diff_pipe[DIFF_LAST]) + SUM_W'(pw_acc_reg[POW_STEPS-1]);

    always_ff @(posedge clk)
    begin
        logic [COL_W+SUM_W-1:0] p_lit;
        logic [COL_W+SUM_W-1:0] p_col;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_lit = (COL_W+SUM_W)'(light_color_reg[16*i +: COL_W])
                        * (COL_W+SUM_W)'(sum_c);
                total_reg[i] <= SUM_W'(ambient_color_reg[16*i +: COL_W])
                                + p_lit[16 +: SUM_W];
                p_col = (COL_W+SUM_W)'(alb_pipe[IC1][i]) * (COL_W+SUM_W)'(total_reg[i]);
                col_reg[i] <= (p_col[COL_W+SUM_W-1:32] != '0) ? {COL_W{1'b1}}
                                                              : p_col[16 +: COL_W];
            end
        end
    end

    // output register and skid entry
    logic                  out_valid_reg;
    logic [2:0][COL_W-1:0] out_reg;
    logic [2:0][COL_W-1:0] skid_reg;
    logic                  take;

    assign take = out_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_ready)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            out_valid_reg <= vld_reg[IC2];
        end
        else if (vld_reg[IC2])
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (take)
        begin
            out_reg <= col_reg;
        end
        else
        begin
            skid_reg <= col_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign color_r   = out_reg[0];
    assign color_g   = out_reg[1];
    assign color_b   = out_reg[2];

endmodule

// ===== hw/rtl/bps_checker.sv =====
module bps_checker
    import bps_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [COL_W-1:0] color_r,
    input logic [COL_W-1:0] color_g,
    input logic [COL_W-1:0] color_b
);

    // stalled transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(color_r)
                                    && $stable(color_g) && $stable(color_b))
        else $error("output transaction changed while stalled");

    // input side closes only when a result is already waiting
    a_block_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no pending output");

    a_fall_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("in_ready dropped without a receiver stall");

    a_rise_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(out_ready))
        else $error("in_ready reopened without an output transaction");

endmodule

bind blinn_phong_pixel_shader_unit bps_checker u_bps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .color_r   (color_r),
    .color_g   (color_g),
    .color_b   (color_b)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bps_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int PIPE_DRAIN  = 110;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;

    typedef longint vec_t [0:2];

    typedef struct {
        logic [15:0]        alb_r;
        logic [15:0]        alb_g;
        logic [15:0]        alb_b;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [23:0] wx;
        logic signed [23:0] wy;
        logic signed [23:0] wz;
    } fragment_t;

    typedef struct {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } color_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [COL_W-1:0]      albedo_r;
    logic [COL_W-1:0]      albedo_g;
    logic [COL_W-1:0]      albedo_b;
    logic [DIR_W-1:0]      normal_x;
    logic [DIR_W-1:0]      normal_y;
    logic [DIR_W-1:0]      normal_z;
    logic [POS_W-1:0]      world_x;
    logic [POS_W-1:0]      world_y;
    logic [POS_W-1:0]      world_z;
    logic                  out_valid;
    logic                  out_ready;
    logic [COL_W-1:0]      color_r;
    logic [COL_W-1:0]      color_g;
    logic [COL_W-1:0]      color_b;

    // shadow copy of the block's registers
    logic [47:0]        sh_light_dir;
    logic [47:0]        sh_light_color;
    logic [47:0]        sh_ambient;
    logic signed [23:0] sh_eye_x;
    logic signed [23:0] sh_eye_y;
    logic signed [23:0] sh_eye_z;
    logic [7:0]         sh_shininess;

    color_t pending_colors [$];
    int     mismatches;
    int     idle_cycles;
    bit     tx_burst;
    bit     rx_burst;
    bit     hold_request;

    blinn_phong_pixel_shader_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .albedo_r  (albedo_r),
        .albedo_g  (albedo_g),
        .albedo_b  (albedo_b),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .world_x   (world_x),
        .world_y   (world_y),
        .world_z   (world_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .color_r   (color_r),
        .color_g   (color_g),
        .color_b   (color_b)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic vec_t to_unit(input vec_t v);
        vec_t            u;
        longint unsigned sq;
        longint          root;
        longint          q;
        sq = longint'(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        u  = '{0, 0, 0};
        if (sq != 0)
        begin
            root = longint'(int_sqrt(sq << 12));
            for (int i = 0; i < 3; i++)
            begin
                q = (v[i] * (64'sd1 <<< 19)) / root;
                if (q > 8192)
                    q = 8192;
                if (q < -8192)
                    q = -8192;
                u[i] = q;
            end
        end
        return u;
    endfunction

    function automatic longint facing(input vec_t a, input vec_t b);
        longint d;
        d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        if (d < 0)
            d = 0;
        if (d > (64'sd1 <<< 26))
            d = 64'sd1 <<< 26;
        return d >>> 10;
    endfunction

    function automatic longint spec_power(input longint base, input logic [7:0] expo);
        longint acc;
        acc = 65536;
        for (int i = 0; i < 8; i++)
        begin
            if (expo[i])
                acc = (acc * base) >>> 16;
            base = (base * base) >>> 16;
        end
        return acc;
    endfunction

    function automatic color_t shade_fragment(input fragment_t f);
        vec_t   nrm;
        vec_t   lgt;
        vec_t   view;
        vec_t   half_v;
        vec_t   nu;
        vec_t   lu;
        vec_t   vu;
        vec_t   hu;
        longint lit_sum;
        longint alb;
        longint lc;
        longint ac;
        longint total;
        longint c;
        longint chan [0:2];
        color_t res;
        nrm  = '{longint'(f.nx), longint'(f.ny), longint'(f.nz)};
        for (int i = 0; i < 3; i++)
            lgt[i] = longint'($signed(sh_light_dir[16*i +: 16]));
        view = '{longint'(sh_eye_x) - longint'(f.wx),
                 longint'(sh_eye_y) - longint'(f.wy),
                 longint'(sh_eye_z) - longint'(f.wz)};
        nu = to_unit(nrm);
        lu = to_unit(lgt);
        vu = to_unit(view);
        for (int i = 0; i < 3; i++)
            half_v[i] = lu[i] + vu[i];
        hu = to_unit(half_v);
        lit_sum = facing(nu, lu) + spec_power(facing(nu, hu), sh_shininess);
        for (int i = 0; i < 3; i++)
        begin
            alb   = (i == 0) ? longint'(f.alb_r) : (i == 1) ? longint'(f.alb_g)
                                                           : longint'(f.alb_b);
            lc    = longint'(sh_light_color[16*i +: 16]);
            ac    = longint'(sh_ambient[16*i +: 16]);
            total = ac + ((lc * lit_sum) >>> 16);
            c     = (alb * total) >>> 16;
            if (c > 65535)
                c = 65535;
            chan[i] = c;
        end
        res.r = chan[0][15:0];
        res.g = chan[1][15:0];
        res.b = chan[2][15:0];
        return res;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_LIGHT_DIR:     sh_light_dir   = value;
            REG_LIGHT_COLOR:   sh_light_color = value;
            REG_AMBIENT_COLOR: sh_ambient     = value;
            REG_EYE_X:         sh_eye_x       = value[23:0];
            REG_EYE_Y:         sh_eye_y       = value[23:0];
            REG_EYE_Z:         sh_eye_z       = value[23:0];
            REG_SHININESS:     sh_shininess   = value[7:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until the pipeline is empty before touching registers
    task automatic drain;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic send_fragment(input fragment_t f);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        albedo_r <= f.alb_r;
        albedo_g <= f.alb_g;
        albedo_b <= f.alb_b;
        normal_x <= f.nx;
        normal_y <= f.ny;
        normal_z <= f.nz;
        world_x  <= f.wx;
        world_y  <= f.wy;
        world_z  <= f.wz;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        pending_colors.push_back(shade_fragment(f));
    endtask

    task automatic finish_stream;
        in_valid <= 1'b0;
    endtask

    function automatic fragment_t random_fragment;
        fragment_t f;
        f.alb_r = $urandom;
        f.alb_g = $urandom;
        f.alb_b = $urandom;
        // mostly short normals, sometimes the full range
        if ($urandom_range(0, 3) == 0)
        begin
            f.nx = $urandom;
            f.ny = $urandom;
            f.nz = $urandom;
        end
        else
        begin
            f.nx = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            f.ny = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            f.nz = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
        end
        f.wx = $urandom;
        f.wy = $urandom;
        f.wz = $urandom;
        return f;
    endfunction

    function automatic fragment_t make_fragment(
        input logic [15:0] a, input logic signed [15:0] x, input logic signed [15:0] y,
        input logic signed [15:0] z, input logic signed [23:0] px,
        input logic signed [23:0] py, input logic signed [23:0] pz);
        fragment_t f;
        f.alb_r = a;
        f.alb_g = a;
        f.alb_b = a;
        f.nx = x;
        f.ny = y;
        f.nz = z;
        f.wx = px;
        f.wy = py;
        f.wz = pz;
        return f;
    endfunction

    task automatic test_default_registers;
        send_fragment(make_fragment(16'hFFFF, 16'sd8192, 0, 0, -24'sd4096, 0, 0));
        send_fragment(make_fragment(16'h0000, 16'sd8192, 0, 0, 24'sd4096, 24'sd4096, 0));
        send_fragment(make_fragment(16'h8000, 0, 0, 0, 24'sd100, 24'sd200, 24'sd300));
        send_fragment(make_fragment(16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                    24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
        send_fragment(make_fragment(16'hFFFF, -16'sd32768, -16'sd32768, -16'sd32768,
                                    -24'sd8388608, -24'sd8388608, -24'sd8388608));
        send_fragment(make_fragment(16'h1234, 16'sd8192, 16'sd8192, 0, 0, 0, 0));
        // view opposite the light: half vector vanishes
        send_fragment(make_fragment(16'hFFFF, 16'sd8192, 0, 0, 24'sd40960, 0, 0));
        send_fragment(make_fragment(16'hFFFF, -16'sd8192, 0, 0, -24'sd4096, 0, 0));
        finish_stream();
        drain();
    endtask

    task automatic test_register_extremes;
        write_reg(REG_AMBIENT_COLOR, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SHININESS, 48'd0);
        write_reg(REG_EYE_X, 48'h7FFFFF);
        write_reg(REG_EYE_Y, 48'h800000);
        write_reg(REG_EYE_Z, 48'h000000);
        send_fragment(make_fragment(16'hFFFF, 16'sd8192, 0, 0, 0, 0, 0));
        send_fragment(make_fragment(16'hFFFF, 0, 16'sd8192, 16'sd8192, 0, 0, 0));
        send_fragment(make_fragment(16'h7FFF, 16'sd1, 0, 0, 24'sh7FFFFF, -24'sd8388608, 0));
        finish_stream();
        drain();
        write_reg(REG_LIGHT_DIR, 48'd0);
        write_reg(REG_LIGHT_COLOR, 48'd0);
        write_reg(REG_AMBIENT_COLOR, 48'd0);
        write_reg(REG_SHININESS, 48'd128);
        send_fragment(make_fragment(16'hFFFF, 16'sd8192, 0, 0, 0, 0, 0));
        send_fragment(make_fragment(16'hFFFF, 0, 0, 16'sd100, 0, 0, -24'sd4096));
        finish_stream();
        drain();
        write_reg(REG_LIGHT_DIR, {16'h8000, 16'h7FFF, 16'h2000});
        write_reg(REG_LIGHT_COLOR, 48'h8000_FFFF_0001);
        write_reg(REG_SHININESS, 48'd1);
        write_reg(REG_EYE_X, 48'd0);
        write_reg(REG_EYE_Y, 48'd0);
        send_fragment(make_fragment(16'hFFFF, 16'sd8192, 16'sd8192, -16'sd8192, 0, 0, 0));
        send_fragment(make_fragment(16'hABCD, 16'sd5, -16'sd3, 16'sd7, 24'sd9, 0, 24'sd12));
        finish_stream();
        drain();
    endtask

    task automatic randomize_registers;
        write_reg(REG_LIGHT_DIR, 48'({$urandom, $urandom}));
        write_reg(REG_LIGHT_COLOR, 48'({$urandom, $urandom}));
        write_reg(REG_AMBIENT_COLOR, ($urandom_range(0, 1) == 0) ? 48'd0
                                     : {16'($urandom), $urandom} >> $urandom_range(2, 8));
        write_reg(REG_EYE_X, 48'($urandom));
        write_reg(REG_EYE_Y, 48'($urandom));
        write_reg(REG_EYE_Z, 48'($urandom));
        write_reg(REG_SHININESS, 48'($urandom_range(1, 128)));
    endtask

    task automatic test_backpressure;
        randomize_registers();
        tx_burst     = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 150; i++)
            send_fragment(random_fragment());
        finish_stream();
        tx_burst = 1'b0;
        drain();
    endtask

    task automatic test_random_stream;
        for (int phase = 0; phase < 8; phase++)
        begin
            randomize_registers();
            for (int i = 0; i < 100; i++)
            begin
                if (i % 25 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);
                send_fragment(random_fragment());
            end
            finish_stream();
            tx_burst = 1'b0;
            drain();
        end
    endtask

    // result side: random stall, optional long hold, then compare
    initial
    begin
        color_t seen;
        color_t want;
        int     stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 40) == 0)
                    rx_burst = ~rx_burst;
                stall = rx_burst ? 0 : $urandom_range(0, 8);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do
                @(negedge clk);
            while (!out_valid);
            seen.r = color_r;
            seen.g = color_g;
            seen.b = color_b;
            @(posedge clk);
            if (pending_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: color %h %h %h",
                             seen.r, seen.g, seen.b);
            end
            else
            begin
                want = pending_colors.pop_front();
                if (seen.r !== want.r || seen.g !== want.g || seen.b !== want.b)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch: expected %h %h %h, got %h %h %h",
                                 want.r, want.g, want.b, seen.r, seen.g, seen.b);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        albedo_r       = '0;
        albedo_g       = '0;
        albedo_b       = '0;
        normal_x       = '0;
        normal_y       = '0;
        normal_z       = '0;
        world_x        = '0;
        world_y        = '0;
        world_z        = '0;
        mismatches     = 0;
        idle_cycles    = 0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        hold_request   = 1'b0;
        sh_light_dir   = 48'd8192;
        sh_light_color = 48'hFFFF_FFFF_FFFF;
        sh_ambient     = 48'd0;
        sh_eye_x       = '0;
        sh_eye_y       = '0;
        sh_eye_z       = '0;
        sh_shininess   = 8'd10;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_registers();
        test_register_extremes();
        test_backpressure();
        test_random_stream();

        drain();
        if (mismatches == 0 && pending_colors.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
